[design/tq_pkg.sv]
// ----------------------------------------------------------------------------
// tq_pkg: shared types and constants of the timer queue scheduler
// Widths, status and command codes, and the timer entry carried by each cell.
// ----------------------------------------------------------------------------
package tq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int TIME_BITS   = 48;
  localparam int OUT_TIME_W  = 48;
  localparam int ID_W        = 32;
  localparam int TAG_W       = 16;
  localparam int PER_W       = 16;
  localparam int TOL_W       = 10;
  localparam int MS_W        = 10;
  localparam int PER_US_W    = PER_W + MS_W;
  localparam int MAX_OUT     = 16;
  localparam int CNT_W       = $clog2(MAX_OUT + 1);
  localparam int DIV_CNT_W   = $clog2(TIME_BITS);

  localparam logic [MS_W-1:0]  MS_TO_US  = MS_W'(1000);
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(12);

  localparam logic [1:0] KIND_ADD_ONCE     = 2'd0;
  localparam logic [1:0] KIND_ADD_PERIODIC = 2'd1;
  localparam logic [1:0] KIND_CANCEL       = 2'd2;
  localparam logic [1:0] KIND_TICK         = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_REJECTED  = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FIRED     = 3'd4;

  typedef struct packed {
    logic                 valid;
    logic                 done;
    logic [ID_W-1:0]      id;
    logic [TIME_BITS-1:0] expiry;
    logic [PER_W-1:0]     period;
    logic                 periodic;
    logic [TAG_W-1:0]     tag;
  } entry_t;

endpackage

[design/tq_cell.sv]
// ----------------------------------------------------------------------------
// tq_cell: one timer slot of the rotating ring
// Holds one entry and takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module tq_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  tq_pkg::entry_t d,
  output tq_pkg::entry_t q
);

  tq_pkg::entry_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (shift) begin
      held <= d;
    end
  end

  assign q = held;

endmodule

[design/tq_div.sv]
// ----------------------------------------------------------------------------
// tq_div: restoring remainder unit
// One quotient bit a cycle; gives dividend modulo divisor.
// ----------------------------------------------------------------------------
module tq_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tq_pkg::TIME_BITS-1:0]   dividend,
  input  logic [tq_pkg::PER_US_W-1:0]    divisor,
  output logic                           done,
  output logic [tq_pkg::PER_US_W-1:0]    remainder
);

  logic [tq_pkg::TIME_BITS-1:0] dvd;
  logic [tq_pkg::PER_US_W-1:0]  dvs;
  logic [tq_pkg::PER_US_W:0]    rem;
  logic [tq_pkg::PER_US_W:0]    rem_sh;
  logic [tq_pkg::DIV_CNT_W-1:0] cnt;
  logic                         busy;
  logic                         ge;

  assign rem_sh = {rem[tq_pkg::PER_US_W-1:0], dvd[tq_pkg::TIME_BITS-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        dvd <= dvd << 1;
        rem <= ge ? rem_sh - {1'b0, dvs} : rem_sh;
        cnt <= cnt + 1'b1;
        if (cnt == tq_pkg::DIV_CNT_W'(tq_pkg::TIME_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[tq_pkg::PER_US_W-1:0];

endmodule

[design/timer_queue_scheduler_core.sv]
// Add and cancel: the beat is taken, the ring makes one full rotation, then
// one result beat (two for a periodic add that fires at once).
// Tick: a first search pass over the ring, then per fired entry the bit-serial
// re-arm remainder and a further ring pass.
// One item at a time; in_ready is high only while idle; a zero-period add skips the ring.
// Reset (rst, synchronous): all slots empty, now and id counter zero, tolerance 12 us.
// ----------------------------------------------------------------------------
// timer_queue_scheduler_core: software timer table in a ring of cells
// Timer slots rotate through a ring; the head cell is searched and updated
// in place, one slot per cycle, with a shared remainder unit for re-arming.
// ----------------------------------------------------------------------------
module timer_queue_scheduler_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      kind,
  input  logic [tq_pkg::PER_W-1:0]        period_ms,
  input  logic                            fire_at_once,
  input  logic [tq_pkg::TAG_W-1:0]        job_tag,
  input  logic [tq_pkg::ID_W-1:0]         target_id,
  input  logic [15:0]                     elapsed_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic [tq_pkg::ID_W-1:0]         timer_id,
  output logic [tq_pkg::TAG_W-1:0]        fired_tag,
  output logic [tq_pkg::OUT_TIME_W-1:0]   scheduled_time,
  output logic                            last,
  input  logic                            cfg_wen,
  input  logic [tq_pkg::TOL_W-1:0]        cfg_wdata
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_SCAN      = 9'b000000010,
    S_EMIT_A    = 9'b000000100,
    S_EMIT_B    = 9'b000001000,
    S_PUSH      = 9'b000010000,
    S_DIV_SETUP = 9'b000100000,
    S_DIV_START = 9'b001000000,
    S_DIV_RUN   = 9'b010000000,
    S_PUSH_LAST = 9'b100000000
  } state_t;

  state_t state;

  // operation context
  logic [1:0]                      op_kind;
  logic                            op_fire_at_once;
  logic [tq_pkg::TAG_W-1:0]        op_tag;
  logic [tq_pkg::ID_W-1:0]         op_target;
  logic [tq_pkg::PER_W-1:0]        op_period;
  logic [tq_pkg::PER_US_W-1:0]     p_us;
  logic [tq_pkg::TIME_BITS-1:0]    now_us;
  logic [tq_pkg::ID_W-1:0]         next_id;
  logic [tq_pkg::TOL_W-1:0]        tol;

  // scan bookkeeping
  logic [tq_pkg::SLOT_W-1:0]       scan_k;
  logic                            found;
  logic                            first_pass;
  logic                            apply;
  logic [tq_pkg::CNT_W-1:0]        fire_cnt;
  logic                            best_valid;
  logic [tq_pkg::SLOT_W-1:0]       best_k;
  tq_pkg::entry_t                  best;
  tq_pkg::entry_t                  pend;
  logic [tq_pkg::SLOT_W-1:0]       pend_k;
  logic [tq_pkg::TIME_BITS-1:0]    nx;

  // result staging
  logic [2:0]                      res_status;
  logic [tq_pkg::ID_W-1:0]         res_id;
  logic [tq_pkg::TIME_BITS-1:0]    res_sched;
  logic                            imm;
  logic                            out_load;

  // ring
  tq_pkg::entry_t                  ring_q [tq_pkg::TIMER_SLOTS];
  tq_pkg::entry_t                  ring_d [tq_pkg::TIMER_SLOTS];
  tq_pkg::entry_t                  head;
  tq_pkg::entry_t                  head_mod;
  logic                            ring_shift;

  logic                            is_add, is_cancel, is_tick;
  logic                            hit_add, hit_cancel, cand, better, due, is_kb, done_eff;
  logic                            pass_end, found_f, ofree, in_acc;
  logic [tq_pkg::TIME_BITS-1:0]    arm_time;

  logic                            div_start, div_done;
  logic [tq_pkg::PER_US_W-1:0]     div_rem;

  assign in_ready   = (state == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign ofree      = !out_valid || out_ready;
  assign ring_shift = (state == S_SCAN);
  assign pass_end   = (scan_k == tq_pkg::SLOT_W'(tq_pkg::TIMER_SLOTS - 1));

  assign is_add    = (op_kind == tq_pkg::KIND_ADD_ONCE) || (op_kind == tq_pkg::KIND_ADD_PERIODIC);
  assign is_cancel = (op_kind == tq_pkg::KIND_CANCEL);
  assign is_tick   = (op_kind == tq_pkg::KIND_TICK);

  assign head     = ring_q[0];
  assign arm_time = now_us + tq_pkg::TIME_BITS'(p_us);

  // head cell inspection and in-place update
  always_comb begin
    due = (head.expiry <= now_us) ||
          ((head.expiry - now_us) <= tq_pkg::TIME_BITS'(tol));
    done_eff   = first_pass ? 1'b0 : head.done;
    is_kb      = apply && (scan_k == pend_k);
    hit_add    = is_add && !found && !head.valid;
    hit_cancel = is_cancel && !found && head.valid && (head.id == op_target);
    cand       = is_tick && head.valid && !done_eff && !is_kb && due &&
                 (fire_cnt < tq_pkg::CNT_W'(tq_pkg::MAX_OUT));
    better     = !best_valid || (head.expiry < best.expiry) ||
                 ((head.expiry == best.expiry) && (head.id < best.id));

    head_mod = head;
    if (is_tick && first_pass) begin
      head_mod.done = 1'b0;
    end
    if (hit_add) begin
      head_mod.valid    = 1'b1;
      head_mod.done     = 1'b0;
      head_mod.id       = next_id;
      head_mod.expiry   = arm_time;
      head_mod.period   = op_period;
      head_mod.periodic = (op_kind == tq_pkg::KIND_ADD_PERIODIC);
      head_mod.tag      = op_tag;
    end
    if (hit_cancel) begin
      head_mod.valid = 1'b0;
    end
    // finish the entry fired in the previous pass: re-arm or free
    if (is_tick && is_kb) begin
      head_mod.done = 1'b1;
      if (pend.periodic) begin
        head_mod.expiry = nx;
      end else begin
        head_mod.valid = 1'b0;
      end
    end
    found_f = found || hit_add || hit_cancel;
  end

  // rotate toward slot 0; the updated head re-enters at the tail
  always_comb begin
    for (int i = 0; i < tq_pkg::TIMER_SLOTS; i++) begin
      ring_d[i] = (i == tq_pkg::TIMER_SLOTS - 1) ? head_mod : ring_q[(i + 1) % tq_pkg::TIMER_SLOTS];
    end
  end

  for (genvar g = 0; g < tq_pkg::TIMER_SLOTS; g++) begin : g_cell
    tq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ring_shift),
      .d     (ring_d[g]),
      .q     (ring_q[g])
    );
  end

  assign div_start = (state == S_DIV_START);

  tq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (now_us - pend.expiry),
    .divisor   (p_us),
    .done      (div_done),
    .remainder (div_rem)
  );

  // load the output register whenever a result beat is handed out
  always_comb begin
    out_load = 1'b0;
    if (ofree) begin
      case (state)
        S_EMIT_A, S_EMIT_B, S_PUSH_LAST: out_load = 1'b1;
        S_PUSH:                          out_load = apply;
        default:                         out_load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now_us     <= '0;
      next_id    <= '0;
      tol        <= tq_pkg::TOL_RESET;
      scan_k     <= '0;
      found      <= 1'b0;
      first_pass <= 1'b0;
      apply      <= 1'b0;
      fire_cnt   <= '0;
      best_valid <= 1'b0;
      imm        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        tol <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_kind         <= kind;
            op_fire_at_once <= fire_at_once;
            op_tag          <= job_tag;
            op_target       <= target_id;
            op_period       <= period_ms;
            p_us            <= tq_pkg::PER_US_W'(period_ms) *
                               tq_pkg::PER_US_W'(tq_pkg::MS_TO_US);
            found           <= 1'b0;
            first_pass      <= 1'b1;
            apply           <= 1'b0;
            fire_cnt        <= '0;
            best_valid      <= 1'b0;
            scan_k          <= '0;
            if (kind == tq_pkg::KIND_TICK) begin
              now_us <= now_us + tq_pkg::TIME_BITS'(elapsed_us);
            end
            if ((kind == tq_pkg::KIND_ADD_ONCE || kind == tq_pkg::KIND_ADD_PERIODIC) &&
                period_ms == '0) begin
              // zero period: reject without touching the table
              res_status <= tq_pkg::ST_REJECTED;
              res_id     <= '1;
              res_sched  <= '0;
              imm        <= 1'b0;
              state      <= S_EMIT_A;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // the slot counter wraps back to zero at the end of a pass
          scan_k <= scan_k + 1'b1;
          if (hit_add || hit_cancel) begin
            found <= 1'b1;
          end
          if (cand && better) begin
            best_valid <= 1'b1;
            best       <= head;
            best_k     <= scan_k;
          end
          if (pass_end) begin
            if (is_add) begin
              res_status <= found_f ? tq_pkg::ST_ADDED : tq_pkg::ST_REJECTED;
              res_id     <= found_f ? next_id : '1;
              res_sched  <= found_f ? arm_time : '0;
              imm        <= found_f && (op_kind == tq_pkg::KIND_ADD_PERIODIC) &&
                            op_fire_at_once;
              if (found_f) begin
                next_id <= next_id + 1'b1;
              end
              state <= S_EMIT_A;
            end else if (is_cancel) begin
              res_status <= found_f ? tq_pkg::ST_CANCELLED : tq_pkg::ST_NOT_FOUND;
              res_id     <= op_target;
              res_sched  <= '0;
              imm        <= 1'b0;
              state      <= S_EMIT_A;
            end else if (best_valid || cand) begin
              state <= S_PUSH;
            end else if (apply) begin
              state <= S_PUSH_LAST;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_EMIT_A: begin
          if (ofree) begin
            status         <= res_status;
            timer_id       <= res_id;
            fired_tag      <= '0;
            scheduled_time <= res_sched[tq_pkg::OUT_TIME_W-1:0];
            last           <= !imm;
            state          <= imm ? S_EMIT_B : S_IDLE;
          end
        end

        S_EMIT_B: begin
          if (ofree) begin
            status         <= tq_pkg::ST_FIRED;
            timer_id       <= res_id;
            fired_tag      <= op_tag;
            scheduled_time <= now_us[tq_pkg::OUT_TIME_W-1:0];
            last           <= 1'b1;
            state          <= S_IDLE;
          end
        end

        S_PUSH: begin
          // hand out the previous fire (not last), then hold the new winner
          if (!apply || ofree) begin
            if (apply) begin
              status         <= tq_pkg::ST_FIRED;
              timer_id       <= pend.id;
              fired_tag      <= pend.tag;
              scheduled_time <= pend.expiry[tq_pkg::OUT_TIME_W-1:0];
              last           <= 1'b0;
            end
            pend     <= best;
            pend_k   <= best_k;
            fire_cnt <= fire_cnt + 1'b1;
            state    <= S_DIV_SETUP;
          end
        end

        S_DIV_SETUP: begin
          p_us  <= tq_pkg::PER_US_W'(pend.period) * tq_pkg::PER_US_W'(tq_pkg::MS_TO_US);
          state <= S_DIV_START;
        end

        S_DIV_START: begin
          state <= S_DIV_RUN;
        end

        S_DIV_RUN: begin
          if (div_done) begin
            // next fire time lies one period past the last missed slot
            if (pend.expiry > now_us) begin
              nx <= pend.expiry + tq_pkg::TIME_BITS'(p_us);
            end else begin
              nx <= now_us - tq_pkg::TIME_BITS'(div_rem) + tq_pkg::TIME_BITS'(p_us);
            end
            apply      <= 1'b1;
            first_pass <= 1'b0;
            best_valid <= 1'b0;
            scan_k     <= '0;
            state      <= S_SCAN;
          end
        end

        S_PUSH_LAST: begin
          if (ofree) begin
            status         <= tq_pkg::ST_FIRED;
            timer_id       <= pend.id;
            fired_tag      <= pend.tag;
            scheduled_time <= pend.expiry[tq_pkg::OUT_TIME_W-1:0];
            last           <= 1'b1;
            apply          <= 1'b0;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the ring must sit at its home alignment whenever no pass is running
  a_ring_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (scan_k == '0))
    else $error("ring rotation left unaligned");

  a_fire_bound: assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= tq_pkg::CNT_W'(tq_pkg::MAX_OUT))
    else $error("tick fired more entries than allowed");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != S_IDLE))
    else $error("accepted beat did not start work");

  a_pending_only_in_tick: assert property (@(posedge clk) disable iff (rst)
    apply |-> is_tick)
    else $error("pending fire outside a tick");

endmodule

[verif/tb_timer_queue_scheduler_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timer_queue_scheduler_core: self-checking regression of the timer table
// Drives adds, cancels and ticks through the valid/ready input channel. A
// local model of the timer table predicts every result beat, and each beat
// leaving the block is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_timer_queue_scheduler_core;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 1200;
  localparam int RANDOM_ITEMS   = 360;

  typedef struct packed {
    logic [2:0]                    status;
    logic [tq_pkg::ID_W-1:0]       timer_id;
    logic [tq_pkg::TAG_W-1:0]      fired_tag;
    logic [tq_pkg::OUT_TIME_W-1:0] sched;
    logic                          last;
  } beat_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [tq_pkg::PER_W-1:0] period;
    logic                     fire_at_once;
    logic [tq_pkg::TAG_W-1:0] tag;
    logic [tq_pkg::ID_W-1:0]  target;
    logic [15:0]              elapsed;
  } cmd_t;

  // Directed row: a command plus an optional typed-in first result.
  typedef struct packed {
    cmd_t  cmd;
    logic  has_fixed;
    beat_t fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = tq_pkg::KIND_TICK;
  logic [tq_pkg::PER_W-1:0] period_ms = '0;
  logic fire_at_once = 1'b0;
  logic [tq_pkg::TAG_W-1:0] job_tag = '0;
  logic [tq_pkg::ID_W-1:0] target_id = '0;
  logic [15:0] elapsed_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [tq_pkg::ID_W-1:0] timer_id;
  logic [tq_pkg::TAG_W-1:0] fired_tag;
  logic [tq_pkg::OUT_TIME_W-1:0] scheduled_time;
  logic last;
  logic cfg_wen = 1'b0;
  logic [tq_pkg::TOL_W-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  timer_queue_scheduler_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .period_ms(period_ms), .fire_at_once(fire_at_once), .job_tag(job_tag),
    .target_id(target_id), .elapsed_us(elapsed_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .timer_id(timer_id), .fired_tag(fired_tag),
    .scheduled_time(scheduled_time), .last(last),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  // Timer table mirror.
  logic [tq_pkg::TIME_BITS-1:0] m_now;
  logic [tq_pkg::ID_W-1:0]      m_next_id;
  logic [tq_pkg::TOL_W-1:0]     m_tol;
  tq_pkg::entry_t               m_tab [tq_pkg::TIMER_SLOTS];

  beat_t pending_beats[$];
  beat_t fixed_beats[$];   // typed-in first results, keyed by beat order below
  int    fixed_at[$];      // index into beat stream where each fixed beat lands
  int    beats_predicted = 0;
  int    beats_seen = 0;
  int    errors = 0;
  int    fired_count = 0;
  int    items_sent = 0;
  bit    noisy = 1'b1;
  int    idle_cycles = 0;
  bit    timed_out = 1'b0;
  beat_t got;
  beat_t want;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH @%0t beat %0d: %s", $realtime, beats_seen, what);
  endtask

  function automatic beat_t make_beat(logic [2:0] st, logic [tq_pkg::ID_W-1:0] id,
                                      logic [tq_pkg::TAG_W-1:0] tg,
                                      logic [tq_pkg::TIME_BITS-1:0] t);
    beat_t b;
    b.status = st;
    b.timer_id = id;
    b.fired_tag = tg;
    b.sched = t[tq_pkg::OUT_TIME_W-1:0];
    b.last = 1'b0;
    return b;
  endfunction

  function automatic bit slot_due(int s);
    logic [tq_pkg::TIME_BITS-1:0] ft;
    ft = m_tab[s].expiry;
    return (ft <= m_now) || ((ft - m_now) <= tq_pkg::TIME_BITS'(m_tol));
  endfunction

  function automatic bit slot_first(int a, int b);
    if (m_tab[a].expiry != m_tab[b].expiry)
      return m_tab[a].expiry < m_tab[b].expiry;
    if (m_tab[a].id != m_tab[b].id)
      return m_tab[a].id < m_tab[b].id;
    return a < b;
  endfunction

  // Advance the fire time of a periodic entry past now.
  function automatic void rearm_slot(int s);
    logic [63:0] p, ft, nx;
    p = 64'(m_tab[s].period) * 64'd1000;
    ft = 64'(m_tab[s].expiry);
    if (p == 0) p = 64'd1000;
    if (ft <= 64'(m_now)) nx = ft + p * ((64'(m_now) - ft) / p + 64'd1);
    else nx = ft + p;
    m_tab[s].expiry = nx[tq_pkg::TIME_BITS-1:0];
  endfunction

  function automatic void reset_table();
    m_now = '0;
    m_next_id = '0;
    m_tol = tq_pkg::TOL_RESET;
    for (int s = 0; s < tq_pkg::TIMER_SLOTS; s++) m_tab[s] = '0;
  endfunction

  // Work out the result beats of one command and queue them.
  function automatic void predict_timers(cmd_t c);
    beat_t res[$];
    int free_slot, hit, best;
    bit fired[tq_pkg::TIMER_SLOTS];
    free_slot = -1;
    hit = -1;
    if (c.kind == tq_pkg::KIND_ADD_ONCE || c.kind == tq_pkg::KIND_ADD_PERIODIC) begin
      for (int s = tq_pkg::TIMER_SLOTS - 1; s >= 0; s--)
        if (!m_tab[s].valid) free_slot = s;
      if (c.period == 0 || free_slot < 0) begin
        res.push_back(make_beat(tq_pkg::ST_REJECTED, '1, '0, '0));
      end else begin
        m_tab[free_slot].valid = 1'b1;
        m_tab[free_slot].id = m_next_id;
        m_tab[free_slot].expiry = m_now + tq_pkg::TIME_BITS'(c.period) *
                                  tq_pkg::TIME_BITS'(1000);
        m_tab[free_slot].period = c.period;
        m_tab[free_slot].periodic = (c.kind == tq_pkg::KIND_ADD_PERIODIC);
        m_tab[free_slot].tag = c.tag;
        res.push_back(make_beat(tq_pkg::ST_ADDED, m_next_id, '0,
                                m_tab[free_slot].expiry));
        if (c.kind == tq_pkg::KIND_ADD_PERIODIC && c.fire_at_once)
          res.push_back(make_beat(tq_pkg::ST_FIRED, m_next_id, c.tag, m_now));
        m_next_id++;
      end
    end else if (c.kind == tq_pkg::KIND_CANCEL) begin
      for (int s = tq_pkg::TIMER_SLOTS - 1; s >= 0; s--)
        if (m_tab[s].valid && m_tab[s].id == c.target) hit = s;
      if (hit >= 0) begin
        m_tab[hit].valid = 1'b0;
        res.push_back(make_beat(tq_pkg::ST_CANCELLED, c.target, '0, '0));
      end else begin
        res.push_back(make_beat(tq_pkg::ST_NOT_FOUND, c.target, '0, '0));
      end
    end else begin
      for (int s = 0; s < tq_pkg::TIMER_SLOTS; s++) fired[s] = 1'b0;
      m_now = m_now + tq_pkg::TIME_BITS'(c.elapsed);
      while (res.size() < tq_pkg::MAX_OUT) begin
        best = -1;
        for (int s = 0; s < tq_pkg::TIMER_SLOTS; s++)
          if (m_tab[s].valid && !fired[s] && slot_due(s))
            if (best < 0 || slot_first(s, best)) best = s;
        if (best < 0) break;
        fired[best] = 1'b1;
        res.push_back(make_beat(tq_pkg::ST_FIRED, m_tab[best].id, m_tab[best].tag,
                                m_tab[best].expiry));
        if (m_tab[best].periodic) rearm_slot(best);
        else m_tab[best].valid = 1'b0;
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_beats.push_back(res[i]);
    beats_predicted += res.size();
  endfunction

  // Present one command and hold it until the block takes the beat.
  task automatic send_cmd(cmd_t c);
    @(negedge clk);
    while (noisy && $urandom_range(99) < 19) @(negedge clk);
    kind <= c.kind;
    period_ms <= c.period;
    fire_at_once <= c.fire_at_once;
    job_tag <= c.tag;
    target_id <= c.target;
    elapsed_us <= c.elapsed;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timers(c);
    items_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0) @(negedge clk);
    // Let an in-flight tick that fires nothing finish its search.
    repeat (tq_pkg::TIMER_SLOTS * 4) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [tq_pkg::TOL_W-1:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_wen <= 1'b1;
    @(negedge clk);
    cfg_wen <= 1'b0;
    m_tol = v;
  endtask

  function automatic cmd_t mk(logic [1:0] k, logic [tq_pkg::PER_W-1:0] p, logic f,
                              logic [tq_pkg::TAG_W-1:0] t, logic [tq_pkg::ID_W-1:0] id,
                              logic [15:0] e);
    cmd_t c;
    c.kind = k; c.period = p; c.fire_at_once = f; c.tag = t; c.target = id; c.elapsed = e;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    int r;
    logic [tq_pkg::ID_W-1:0] tid;
    r = $urandom_range(99);
    // Mostly target ids near the live ones, some anywhere in the 32-bit space.
    tid = ($urandom_range(3) == 0) ? tq_pkg::ID_W'($urandom) :
          m_next_id - tq_pkg::ID_W'($urandom_range(20));
    if (r < 35)
      return mk(tq_pkg::KIND_ADD_ONCE, ($urandom_range(19) == 0) ? tq_pkg::PER_W'($urandom) :
                tq_pkg::PER_W'($urandom_range(($urandom_range(9) == 0) ? 0 : 1, 8)),
                1'($urandom), tq_pkg::TAG_W'($urandom), tq_pkg::ID_W'($urandom),
                16'($urandom));
    if (r < 60)
      return mk(tq_pkg::KIND_ADD_PERIODIC,
                ($urandom_range(19) == 0) ? tq_pkg::PER_W'($urandom) :
                tq_pkg::PER_W'($urandom_range(1, 6)),
                1'($urandom), tq_pkg::TAG_W'($urandom), tq_pkg::ID_W'($urandom),
                16'($urandom));
    if (r < 75)
      return mk(tq_pkg::KIND_CANCEL, tq_pkg::PER_W'($urandom), 1'($urandom),
                tq_pkg::TAG_W'($urandom), tid, 16'($urandom));
    return mk(tq_pkg::KIND_TICK, tq_pkg::PER_W'($urandom), 1'($urandom),
              tq_pkg::TAG_W'($urandom), tq_pkg::ID_W'($urandom),
              ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000)));
  endfunction

  // Output side: random backpressure, compare each beat with the oldest prediction.
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= !(noisy && $urandom_range(99) < 19);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = '{status, timer_id, fired_tag, scheduled_time, last};
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status %0d id %0d", status, timer_id));
      end else begin
        want = pending_beats.pop_front();
        if (fixed_at.size() != 0 && fixed_at[0] == beats_seen) begin
          void'(fixed_at.pop_front());
          if (fixed_beats.pop_front() != got)
            report_mismatch("directed row disagrees with typed-in result");
        end
        if (got.status != want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.timer_id != want.timer_id)
          report_mismatch($sformatf("timer_id %0h, want %0h", got.timer_id, want.timer_id));
        if (got.fired_tag != want.fired_tag)
          report_mismatch($sformatf("fired_tag %0h, want %0h", got.fired_tag,
                                    want.fired_tag));
        if (got.sched != want.sched)
          report_mismatch($sformatf("scheduled_time %0h, want %0h", got.sched, want.sched));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        if (got.status == tq_pkg::ST_FIRED) fired_count++;
      end
      beats_seen++;
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
      $display("timer_queue_scheduler_core regression: fail");
      $finish;
    end
  end

  // Directed rows; fixed results apply only where obvious after reset.
  row_t directed [] = '{
    '{mk(tq_pkg::KIND_ADD_ONCE, 16'd0, 1'b0, 16'h1234, 32'd0, 16'd0), 1'b1,
      '{tq_pkg::ST_REJECTED, 32'hFFFF_FFFF, 16'd0, 48'd0, 1'b1}},
    '{mk(tq_pkg::KIND_CANCEL, 16'd0, 1'b0, 16'd0, 32'hFFFF_FFFF, 16'd0), 1'b1,
      '{tq_pkg::ST_NOT_FOUND, 32'hFFFF_FFFF, 16'd0, 48'd0, 1'b1}},
    '{mk(tq_pkg::KIND_ADD_ONCE, 16'd1, 1'b0, 16'hFFFF, 32'd0, 16'd0), 1'b1,
      '{tq_pkg::ST_ADDED, 32'd0, 16'd0, 48'd1000, 1'b1}},
    '{mk(tq_pkg::KIND_ADD_PERIODIC, 16'd1, 1'b1, 16'hA5A5, 32'd0, 16'd0), 1'b0, '0},
    '{mk(tq_pkg::KIND_ADD_PERIODIC, 16'hFFFF, 1'b0, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF),
      1'b0, '0},
    '{mk(tq_pkg::KIND_ADD_ONCE, 16'd1, 1'b0, 16'h0001, 32'd0, 16'd0), 1'b0, '0},
    '{mk(tq_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0, 32'd0, 16'd0), 1'b0, '0},
    '{mk(tq_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0, 32'd0, 16'd988), 1'b0, '0},
    '{mk(tq_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0, 32'd0, 16'hFFFF), 1'b0, '0},
    '{mk(tq_pkg::KIND_CANCEL, 16'd0, 1'b0, 16'd0, 32'd2, 16'd0), 1'b0, '0},
    '{mk(tq_pkg::KIND_CANCEL, 16'd0, 1'b0, 16'd0, 32'd2, 16'd0), 1'b0, '0},
    '{mk(tq_pkg::KIND_ADD_PERIODIC, 16'd2, 1'b0, 16'h00F0, 32'd0, 16'd0), 1'b0, '0},
    '{mk(tq_pkg::KIND_ADD_PERIODIC, 16'd2, 1'b0, 16'h0F00, 32'd0, 16'd0), 1'b0, '0},
    '{mk(tq_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0, 32'd0, 16'd9000), 1'b0, '0}
  };

  initial begin
    reset_table();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].has_fixed) begin
        fixed_at.push_back(beats_predicted);
        fixed_beats.push_back(directed[i].fixed);
      end
      send_cmd(directed[i].cmd);
    end
    // Fill the table to overflow, then sweep it out with one large tick.
    for (int i = 0; i < tq_pkg::TIMER_SLOTS + 2; i++)
      send_cmd(mk(tq_pkg::KIND_ADD_ONCE, tq_pkg::PER_W'(i + 1), 1'b0, tq_pkg::TAG_W'(i),
                  '0, '0));
    send_cmd(mk(tq_pkg::KIND_TICK, '0, 1'b0, '0, '0, 16'hFFFF));

    write_tolerance('0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 60) write_tolerance('1);
      if (i == 140) write_tolerance(tq_pkg::TOL_W'($urandom));
      if (i == 200) noisy = 1'b0;          // a long stretch at full rate
      if (i == 260) noisy = 1'b1;
      if (i == 300) wait_drained();        // sender holds off until all results land
      send_cmd(random_cmd());
    end
    write_tolerance(tq_pkg::TOL_RESET);
    send_cmd(mk(tq_pkg::KIND_TICK, '0, 1'b0, '0, '0, 16'hFFFF));

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d commands, %0d result beats, %0d timer fires",
             items_sent, beats_seen, fired_count);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("timer_queue_scheduler_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", errors, pending_beats.size());
      $display("timer_queue_scheduler_core regression: fail");
    end
    $finish;
  end

endmodule

[timer_queue_scheduler_core.f]
design/tq_pkg.sv
design/tq_cell.sv
design/tq_div.sv
design/timer_queue_scheduler_core.sv
verif/tb_timer_queue_scheduler_core.sv
